/* src/ocp_pkg.sv */
// Shared types and constants of the oriented box corner projector.
`default_nettype none
package ocp_pkg;

   localparam int COEF_W      = 32;
   localparam int CEN_W       = 32;
   localparam int QUAT_W      = 16;
   localparam int SIZE_W      = 31;
   localparam int QPROD_W     = 32;
   localparam int DPROD_W     = 64;
   localparam int DEPTH_W     = 66;
   localparam int ROT_PRE_W   = 36;
   localparam int ROT_W       = 28;
   localparam int IDX_W       = 3;
   localparam int NUM_COEFS   = 12;
   localparam int NUM_REGS    = 6;
   localparam int PAIR_W      = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int QUOT_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int REQ_DATA_W  = 256;
   localparam int RSP_DATA_W  = 72;

   localparam logic [IDX_W-1:0] LAST_CORNER = 3'd7;

   // Negative half-size signs per corner: bit 0 is x, bit 1 is y, bit 2 is z.
   localparam logic [2:0] CORNER_NEG [8] = '{
      3'b100, 3'b110, 3'b111, 3'b101, 3'b000, 3'b010, 3'b011, 3'b001
   };

   typedef logic [NUM_COEFS-1:0][COEF_W-1:0] coef_set_type;

   typedef struct packed {
      logic [2:0][CEN_W-1:0]  cen;
      logic [8:0][ROT_W-1:0]  rot;
      logic [2:0][SIZE_W-1:0] size;
   } box_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             last;
      box_type          box;
   } corner_req_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             last;
      logic             front;
   } corner_meta_type;

endpackage
`default_nettype wire

/* src/oriented_box_corner_projector.sv */
// Top level of the oriented box corner projector.
//
// A request on the req_ channel carries one 3D box (centre, quaternion, sizes in
// tdata, the box-shape flag in tuser). Boxes that are not boxes, or whose centre
// has a non-positive projected depth, produce nothing. Every other box yields
// eight responses on the rsp_ channel, corners 0 to 7 in order, tlast on the
// eighth, each with pixel u and v and an in-front flag.
// The camera matrix lives in six 64-bit registers on the csr_ port at byte addresses
// 0, 8, ..., 40. The user must write it only while the block is idle; no logic enforces it.
// Throughput is one corner per cycle while the receiver does not stall the
// pipeline; the corner sequencer issues eight corners per box.
// After a box is accepted, its first corner passes three intake stages (the
// accepting edge loads the first), four transform and projection stages, the
// 33-stage divider and the output register before it is offered.
// Reset clears the matrix and empties the pipeline. While rsp_tready is low with a
// response pending the pipeline stalls in place (empty first two intake stages still
// fill); nothing is lost or repeated, and req_tready drops once those two are full.
`default_nettype none
module oriented_box_corner_projector
   import ocp_pkg::*;
#(
   parameter int COORD_WIDTH = 32
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // center_x, center_y, center_z, quat_w, quat_x, quat_y, quat_z,
   // size_x, size_y, size_z (lowest bits first), zero padded
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser, // is_box
   // corner_index, u_coord, v_coord, in_front (lowest bits first), zero padded
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast, // last
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [PAIR_W-1:0]     csr_pwdata,
   output logic [PAIR_W-1:0]          csr_prdata,
   output logic                       csr_pready
);

   localparam int ROW_W = COEF_W + COORD_WIDTH + 2;
   localparam logic [QUOT_W-1:0] Q_POS_MAX = {1'b0, {(QUOT_W-1){1'b1}}};
   localparam logic [QUOT_W-1:0] Q_NEG_MIN = {1'b1, {(QUOT_W-1){1'b0}}};

   logic [PAIR_W-1:0]       pair_ff [NUM_REGS];
   logic [2:0]              csr_idx;
   logic                    csr_wr;
   coef_set_type            coefs;
   logic                    en;
   corner_req_type          corner;
   corner_meta_type         meta;
   corner_meta_type         meta_ff [QUOT_W+1];
   logic signed [ROW_W-1:0] num_u, num_v, den;
   logic [QUOT_W-1:0]       qu, qv;
   logic                    negu, negv, ovfu, ovfv;
   logic [QUOT_W-1:0]       u_in, v_in;
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic                    rsp_last_ff;

   // Register file.
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            pair_ff[i] <= '0;
         end
      end else if (csr_wr && (csr_idx < 3'(NUM_REGS))) begin
         pair_ff[csr_idx] <= csr_pwdata;
      end
   end

   always_comb begin
      csr_prdata = '0;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (csr_idx == 3'(i)) begin
            csr_prdata = pair_ff[i];
         end
      end
   end

   for (genvar i = 0; i < NUM_COEFS; i++) begin : g_coef
      assign coefs[i] = pair_ff[i/2][COEF_W*(i%2) +: COEF_W];
   end

   // The pipeline moves whenever the output register can take a response.
   assign en = !rsp_valid_ff || rsp_tready;

   ocp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .coefs      (coefs),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .corner     (corner)
   );

   ocp_corner #(
      .COORD_WIDTH (COORD_WIDTH),
      .ROW_W       (ROW_W)
   ) u_corner (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .coefs  (coefs),
      .corner (corner),
      .meta   (meta),
      .num_u  (num_u),
      .num_v  (num_v),
      .den    (den)
   );

   ocp_div #(.NUM_W(ROW_W)) u_div_u (
      .clock (clock),
      .en    (en),
      .num   (num_u),
      .den   (den),
      .quot  (qu),
      .neg   (negu),
      .ovf   (ovfu)
   );

   ocp_div #(.NUM_W(ROW_W)) u_div_v (
      .clock (clock),
      .en    (en),
      .num   (num_v),
      .den   (den),
      .quot  (qv),
      .neg   (negv),
      .ovf   (ovfv)
   );

   // Corner tags travel alongside the dividers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QUOT_W; s++) begin
            meta_ff[s].valid <= 1'b0;
         end
      end else if (en) begin
         meta_ff[0].valid <= meta.valid;
         for (int s = 1; s <= QUOT_W; s++) begin
            meta_ff[s].valid <= meta_ff[s-1].valid;
         end
      end
      if (en) begin
         meta_ff[0].idx   <= meta.idx;
         meta_ff[0].last  <= meta.last;
         meta_ff[0].front <= meta.front;
         for (int s = 1; s <= QUOT_W; s++) begin
            meta_ff[s].idx   <= meta_ff[s-1].idx;
            meta_ff[s].last  <= meta_ff[s-1].last;
            meta_ff[s].front <= meta_ff[s-1].front;
         end
      end
   end

   // Sign and saturation of the quotients; zero when behind the camera.
   always_comb begin
      if (!meta_ff[QUOT_W].front) begin
         u_in = '0;
      end else if (negu) begin
         u_in = (ovfu || (qu > Q_NEG_MIN)) ? Q_NEG_MIN : -qu;
      end else begin
         u_in = (ovfu || (qu > Q_POS_MAX)) ? Q_POS_MAX : qu;
      end
      if (!meta_ff[QUOT_W].front) begin
         v_in = '0;
      end else if (negv) begin
         v_in = (ovfv || (qv > Q_NEG_MIN)) ? Q_NEG_MIN : -qv;
      end else begin
         v_in = (ovfv || (qv > Q_POS_MAX)) ? Q_POS_MAX : qv;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= meta_ff[QUOT_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {{(RSP_DATA_W-IDX_W-2*QUOT_W-1){1'b0}}, meta_ff[QUOT_W].front,
                         v_in, u_in, meta_ff[QUOT_W].idx};
         rsp_last_ff <= meta_ff[QUOT_W].last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

/* src/ocp_front.sv */
// Box intake: centre depth test, rotation matrix and the eight-corner sequencer.
`default_nettype none
module ocp_front
   import ocp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire coef_set_type          coefs,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   output corner_req_type             corner
);

   localparam logic signed [ROT_PRE_W-1:0] ROT_ONE  = 36'sd268435456;
   localparam logic signed [ROT_PRE_W-1:0] ROT_HALF = 36'sd128;

   // Stage A: products for the centre depth and the quaternion.
   logic                       a_valid_ff;
   logic signed [DPROD_W-1:0]  a_dprod_ff [3];
   logic signed [QPROD_W-1:0]  a_qprod_ff [9];
   logic [2:0][CEN_W-1:0]      a_cen_ff;
   logic [2:0][SIZE_W-1:0]     a_size_ff;
   logic signed [DPROD_W-1:0]  a_dprod_in [3];
   logic signed [QPROD_W-1:0]  a_qprod_in [9];
   logic [2:0][CEN_W-1:0]      cen_in;
   logic [2:0][SIZE_W-1:0]     size_in;
   logic signed [QUAT_W-1:0]   qw, qx, qy, qz;
   logic                       a_adv;

   // Stage B: depth sign and rounded rotation matrix.
   logic                       b_valid_ff;
   logic                       b_keep_ff;
   box_type                    b_box_ff;
   logic                       b_keep_in;
   box_type                    b_box_in;
   logic signed [DEPTH_W-1:0]  depth;
   logic signed [ROT_PRE_W-1:0] rot_pre [9];
   logic signed [ROT_PRE_W-1:0] rot_rnd [9];
   logic                       b_adv;

   // Sequencer: holds one box and issues a corner each enabled cycle.
   logic                       e_busy_ff;
   logic [IDX_W-1:0]           e_cnt_ff;
   box_type                    e_box_ff;
   logic                       e_load;

   // Field unpacking of the request.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         cen_in[j]  = req_tdata[CEN_W*j +: CEN_W];
         size_in[j] = req_tdata[3*CEN_W + 4*QUAT_W + SIZE_W*j +: SIZE_W];
      end
      qw = $signed(req_tdata[3*CEN_W +: QUAT_W]);
      qx = $signed(req_tdata[3*CEN_W + QUAT_W +: QUAT_W]);
      qy = $signed(req_tdata[3*CEN_W + 2*QUAT_W +: QUAT_W]);
      qz = $signed(req_tdata[3*CEN_W + 3*QUAT_W +: QUAT_W]);
   end

   // Products formed ahead of stage A.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         a_dprod_in[j] = DPROD_W'($signed(coefs[8+j])) * DPROD_W'($signed(cen_in[j]));
      end
      a_qprod_in[0] = QPROD_W'(qx) * QPROD_W'(qx);
      a_qprod_in[1] = QPROD_W'(qy) * QPROD_W'(qy);
      a_qprod_in[2] = QPROD_W'(qz) * QPROD_W'(qz);
      a_qprod_in[3] = QPROD_W'(qx) * QPROD_W'(qy);
      a_qprod_in[4] = QPROD_W'(qw) * QPROD_W'(qz);
      a_qprod_in[5] = QPROD_W'(qx) * QPROD_W'(qz);
      a_qprod_in[6] = QPROD_W'(qw) * QPROD_W'(qy);
      a_qprod_in[7] = QPROD_W'(qy) * QPROD_W'(qz);
      a_qprod_in[8] = QPROD_W'(qw) * QPROD_W'(qx);
   end

   // Depth of the centre and the rotation matrix, rounded to 20 fraction bits.
   always_comb begin
      depth = DEPTH_W'(a_dprod_ff[0]) + DEPTH_W'(a_dprod_ff[1])
            + DEPTH_W'(a_dprod_ff[2])
            + DEPTH_W'($signed({coefs[11], {FRAC_W{1'b0}}}));
      b_keep_in = (depth > 0);
      rot_pre[0] = ROT_ONE - ((ROT_PRE_W'(a_qprod_ff[1]) + ROT_PRE_W'(a_qprod_ff[2])) <<< 1);
      rot_pre[1] = (ROT_PRE_W'(a_qprod_ff[3]) - ROT_PRE_W'(a_qprod_ff[4])) <<< 1;
      rot_pre[2] = (ROT_PRE_W'(a_qprod_ff[5]) + ROT_PRE_W'(a_qprod_ff[6])) <<< 1;
      rot_pre[3] = (ROT_PRE_W'(a_qprod_ff[3]) + ROT_PRE_W'(a_qprod_ff[4])) <<< 1;
      rot_pre[4] = ROT_ONE - ((ROT_PRE_W'(a_qprod_ff[0]) + ROT_PRE_W'(a_qprod_ff[2])) <<< 1);
      rot_pre[5] = (ROT_PRE_W'(a_qprod_ff[7]) - ROT_PRE_W'(a_qprod_ff[8])) <<< 1;
      rot_pre[6] = (ROT_PRE_W'(a_qprod_ff[5]) - ROT_PRE_W'(a_qprod_ff[6])) <<< 1;
      rot_pre[7] = (ROT_PRE_W'(a_qprod_ff[7]) + ROT_PRE_W'(a_qprod_ff[8])) <<< 1;
      rot_pre[8] = ROT_ONE - ((ROT_PRE_W'(a_qprod_ff[0]) + ROT_PRE_W'(a_qprod_ff[1])) <<< 1);
      for (int k = 0; k < 9; k++) begin
         rot_rnd[k]         = rot_pre[k] + ROT_HALF;
         b_box_in.rot[k]    = rot_rnd[k][ROT_PRE_W-1:ROT_PRE_W-ROT_W];
      end
      b_box_in.cen  = a_cen_ff;
      b_box_in.size = a_size_ff;
   end

   // Stage advance conditions, from the sequencer backwards.
   assign e_load     = en && (!e_busy_ff || (e_cnt_ff == LAST_CORNER));
   assign b_adv      = e_load || !b_valid_ff;
   assign a_adv      = b_adv || !a_valid_ff;
   assign req_tready = a_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         e_busy_ff  <= 1'b0;
         e_cnt_ff   <= '0;
      end else begin
         if (a_adv) begin
            a_valid_ff <= req_tvalid && req_tuser;
         end
         if (b_adv) begin
            b_valid_ff <= a_valid_ff;
         end
         if (e_load) begin
            e_busy_ff <= b_valid_ff && b_keep_ff;
            e_cnt_ff  <= '0;
         end else if (en && e_busy_ff) begin
            e_cnt_ff <= e_cnt_ff + 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (a_adv) begin
         a_dprod_ff <= a_dprod_in;
         a_qprod_ff <= a_qprod_in;
         a_cen_ff   <= cen_in;
         a_size_ff  <= size_in;
      end
      if (b_adv) begin
         b_keep_ff <= b_keep_in;
         b_box_ff  <= b_box_in;
      end
      if (e_load) begin
         e_box_ff <= b_box_ff;
      end
   end

   // Corner issued to the transform pipeline.
   always_comb begin
      corner.valid = e_busy_ff;
      corner.idx   = e_cnt_ff;
      corner.last  = (e_cnt_ff == LAST_CORNER);
      corner.box   = e_box_ff;
   end

endmodule
`default_nettype wire

/* src/ocp_corner.sv */
// Corner transform and camera projection: four register stages.
`default_nettype none
module ocp_corner
   import ocp_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int ROW_W       = 66
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire coef_set_type             coefs,
   input  wire corner_req_type           corner,
   output corner_meta_type               meta,
   output logic signed [ROW_W-1:0]       num_u,
   output logic signed [ROW_W-1:0]       num_v,
   output logic signed [ROW_W-1:0]       den
);

   localparam int HALF_W  = SIZE_W + 1;
   localparam int RPROD_W = ROT_W + HALF_W;
   localparam int ACC_W   = RPROD_W + 2;
   localparam int SH_W    = ACC_W - 21;
   localparam int SAT_W   = ((COORD_WIDTH > SH_W) ? COORD_WIDTH : SH_W) + 2;
   localparam int PPROD_W = COEF_W + COORD_WIDTH;
   localparam logic signed [SAT_W-1:0] W_MAX =
      {{(SAT_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [SAT_W-1:0] W_MIN = ~W_MAX;
   localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) <<< 20;

   // Stage 1: rotation products.
   logic                        c1_valid_ff;
   logic [IDX_W-1:0]            c1_idx_ff;
   logic                        c1_last_ff;
   logic [2:0][CEN_W-1:0]       c1_cen_ff;
   logic signed [RPROD_W-1:0]   c1_prod_ff [9];
   logic signed [RPROD_W-1:0]   c1_prod_in [9];
   logic signed [HALF_W-1:0]    half_p [3];

   // Stage 2: corner coordinates.
   logic                        c2_valid_ff;
   logic [IDX_W-1:0]            c2_idx_ff;
   logic                        c2_last_ff;
   logic signed [COORD_WIDTH-1:0] c2_w_ff [3];
   logic signed [COORD_WIDTH-1:0] c2_w_in [3];
   logic signed [ACC_W-1:0]     acc [3];
   logic signed [ACC_W-1:0]     acc_rnd [3];
   logic signed [SAT_W-1:0]     t_sum [3];

   // Stage 3: projection products.
   logic                        c3_valid_ff;
   logic [IDX_W-1:0]            c3_idx_ff;
   logic                        c3_last_ff;
   logic signed [PPROD_W-1:0]   c3_prod_ff [9];
   logic signed [PPROD_W-1:0]   c3_prod_in [9];

   // Stage 4: projection rows.
   logic signed [ROW_W-1:0]     row_in [3];
   logic                        c4_front_in;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         half_p[j] = CORNER_NEG[corner.idx][j] ? -$signed({1'b0, corner.box.size[j]})
                                               :  $signed({1'b0, corner.box.size[j]});
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            c1_prod_in[3*i+j] = RPROD_W'($signed(corner.box.rot[3*i+j]))
                              * RPROD_W'(half_p[j]);
         end
      end
   end

   // Round to Q16.16, add the centre and saturate to the coordinate width.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = ACC_W'(c1_prod_ff[3*i]) + ACC_W'(c1_prod_ff[3*i+1])
                + ACC_W'(c1_prod_ff[3*i+2]);
         acc_rnd[i] = acc[i] + ACC_RND;
         t_sum[i] = SAT_W'($signed(acc_rnd[i][ACC_W-1:21]))
                  + SAT_W'($signed(c1_cen_ff[i]));
         if (t_sum[i] > W_MAX) begin
            c2_w_in[i] = W_MAX[COORD_WIDTH-1:0];
         end else if (t_sum[i] < W_MIN) begin
            c2_w_in[i] = W_MIN[COORD_WIDTH-1:0];
         end else begin
            c2_w_in[i] = t_sum[i][COORD_WIDTH-1:0];
         end
      end
   end

   // Matrix coefficient times coordinate.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            c3_prod_in[3*r+j] = PPROD_W'($signed(coefs[4*r+j])) * PPROD_W'(c2_w_ff[j]);
         end
      end
   end

   // Row sums, including the translation column.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_in[r] = ROW_W'(c3_prod_ff[3*r]) + ROW_W'(c3_prod_ff[3*r+1])
                   + ROW_W'(c3_prod_ff[3*r+2])
                   + ROW_W'($signed({coefs[4*r+3], {FRAC_W{1'b0}}}));
      end
      c4_front_in = (row_in[2] > 0);
   end

   // Valid bits and payload move together whenever the pipeline is enabled.
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
         c3_valid_ff <= 1'b0;
         meta.valid  <= 1'b0;
      end else if (en) begin
         c1_valid_ff <= corner.valid;
         c2_valid_ff <= c1_valid_ff;
         c3_valid_ff <= c2_valid_ff;
         meta.valid  <= c3_valid_ff;
      end
      if (en) begin
         c1_idx_ff  <= corner.idx;
         c1_last_ff <= corner.last;
         c1_cen_ff  <= corner.box.cen;
         c1_prod_ff <= c1_prod_in;
         c2_idx_ff  <= c1_idx_ff;
         c2_last_ff <= c1_last_ff;
         c2_w_ff    <= c2_w_in;
         c3_idx_ff  <= c2_idx_ff;
         c3_last_ff <= c2_last_ff;
         c3_prod_ff <= c3_prod_in;
         meta.idx   <= c3_idx_ff;
         meta.last  <= c3_last_ff;
         meta.front <= c4_front_in;
         num_u      <= row_in[0];
         num_v      <= row_in[1];
         den        <= row_in[2];
      end
   end

endmodule
`default_nettype wire

/* src/ocp_div.sv */
// Pipelined restoring divider: one quotient bit per stage, with overflow flag.
`default_nettype none
module ocp_div
   import ocp_pkg::*;
#(
   parameter int NUM_W = 66
)
(
   input  wire logic                    clock,
   input  wire logic                    en,
   input  wire logic signed [NUM_W-1:0] num,
   input  wire logic signed [NUM_W-1:0] den,
   output logic [QUOT_W-1:0]            quot,
   output logic                         neg,
   output logic                         ovf
);

   logic [NUM_W-1:0]  rem_ff [QUOT_W+1];
   logic [QUOT_W-1:0] low_ff [QUOT_W+1];
   logic [QUOT_W-1:0] q_ff   [QUOT_W+1];
   logic [NUM_W-1:0]  den_ff [QUOT_W+1];
   logic              neg_ff [QUOT_W+1];
   logic              ovf_ff [QUOT_W+1];
   logic [NUM_W-1:0]  mag;

   // Magnitude of the numerator and the overflow test against den * 2^16.
   assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= num[NUM_W-1];
         ovf_ff[0] <= {{FRAC_W{1'b0}}, mag} >= {den, {FRAC_W{1'b0}}};
         rem_ff[0] <= {{FRAC_W{1'b0}}, mag[NUM_W-1:FRAC_W]};
         low_ff[0] <= {mag[FRAC_W-1:0], {FRAC_W{1'b0}}};
         q_ff[0]   <= '0;
         den_ff[0] <= den;
      end
   end

   // One quotient bit per stage.
   for (genvar s = 0; s < QUOT_W; s++) begin : g_step
      logic [NUM_W:0] trial;
      logic [NUM_W:0] diff;
      logic           take;

      assign trial = {rem_ff[s], low_ff[s][QUOT_W-1]};
      assign diff  = trial - {1'b0, den_ff[s]};
      assign take  = trial >= {1'b0, den_ff[s]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= take ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
            low_ff[s+1] <= {low_ff[s][QUOT_W-2:0], 1'b0};
            q_ff[s+1]   <= {q_ff[s][QUOT_W-2:0], take};
            den_ff[s+1] <= den_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
         end
      end
   end

   assign quot = q_ff[QUOT_W];
   assign neg  = neg_ff[QUOT_W];
   assign ovf  = ovf_ff[QUOT_W];

endmodule
`default_nettype wire

/* sim/oriented_box_corner_projector_tb.sv */
// Self-checking testbench for the oriented box corner projector.
`timescale 1ns / 100ps
`default_nettype none
module oriented_box_corner_projector_tb
   import ocp_pkg::*;
;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 60;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic signed [31:0] cx, cy, cz;
      logic signed [15:0] qw, qx, qy, qz;
      logic [30:0]        sx, sy, sz;
      logic               is_box;
   } test_box_type;

   typedef struct packed {
      logic [2:0]  idx;
      logic [31:0] u, v;
      logic        front, last;
   } corner_type;

   // Scoreboard: predicts the eight corners of a box and checks the responses.
   class corner_scoreboard;
      logic [63:0] pair [6];
      corner_type  expected_corners [$];
      int          mismatches;
      int          corners_checked;

      function new();
         foreach (pair[i]) pair[i] = '0;
         mismatches      = 0;
         corners_checked = 0;
      endfunction

      function void set_pair(int idx, logic [63:0] value);
         if (idx < NUM_REGS) pair[idx] = value;
      endfunction

      function longint coef(int i);
         logic signed [31:0] w;
         w = pair[i >> 1][32 * (i & 1) +: 32];
         return longint'(w);
      endfunction

      // One row of the camera matrix applied to (x, y, z, 1), exact.
      function wide_type matrix_row(int r, longint x, longint y, longint z);
         wide_type s;
         s = wide_type'(coef(4 * r)) * wide_type'(x);
         s = s + wide_type'(coef(4 * r + 1)) * wide_type'(y);
         s = s + wide_type'(coef(4 * r + 2)) * wide_type'(z);
         s = s + wide_type'(coef(4 * r + 3)) * wide_type'(65536);
         return s;
      endfunction

      // Quotient truncated towards zero, saturated to 32 signed bits.
      function logic [31:0] pixel_quotient(wide_type num, wide_type den);
         wide_type q;
         q = (num <<< 16) / den;
         if (q > wide_type'(64'sh7FFFFFFF)) q = wide_type'(64'sh7FFFFFFF);
         if (q < wide_type'(-64'sh80000000)) q = wide_type'(-64'sh80000000);
         return q[31:0];
      endfunction

      // Notes an accepted box and returns how many corners it will produce.
      function int note_box(test_box_type b);
         longint     c [3], half [3], p [3], w [3], rot [9];
         longint     qw, qx, qy, qz, acc, t, one, lim;
         wide_type   d;
         corner_type e;
         one = longint'(1) <<< 28;
         lim = (longint'(1) <<< 31) - 1;
         c[0] = b.cx; c[1] = b.cy; c[2] = b.cz;
         half[0] = b.sx; half[1] = b.sy; half[2] = b.sz;
         if (!b.is_box) return 0;
         d = matrix_row(2, c[0], c[1], c[2]);
         if (d <= 0) return 0;
         qw = b.qw; qx = b.qx; qy = b.qy; qz = b.qz;
         rot[0] = one - 2 * (qy * qy + qz * qz);
         rot[1] = 2 * (qx * qy - qw * qz);
         rot[2] = 2 * (qx * qz + qw * qy);
         rot[3] = 2 * (qx * qy + qw * qz);
         rot[4] = one - 2 * (qx * qx + qz * qz);
         rot[5] = 2 * (qy * qz - qw * qx);
         rot[6] = 2 * (qx * qz - qw * qy);
         rot[7] = 2 * (qy * qz + qw * qx);
         rot[8] = one - 2 * (qx * qx + qy * qy);
         foreach (rot[i]) rot[i] = (rot[i] + 128) >>> 8;
         for (int k = 0; k < 8; k++) begin
            // Bottom face first; x and y signs run ++, +-, --, -+.
            p[0] = (k == 2 || k == 3 || k == 6 || k == 7) ? -half[0] : half[0];
            p[1] = (k == 1 || k == 2 || k == 5 || k == 6) ? -half[1] : half[1];
            p[2] = (k < 4) ? -half[2] : half[2];
            for (int i = 0; i < 3; i++) begin
               acc = rot[3 * i] * p[0] + rot[3 * i + 1] * p[1] + rot[3 * i + 2] * p[2];
               t = ((acc + (longint'(1) <<< 20)) >>> 21) + c[i];
               if (t > lim) t = lim;
               if (t < -lim - 1) t = -lim - 1;
               w[i] = t;
            end
            d = matrix_row(2, w[0], w[1], w[2]);
            e.idx   = k[2:0];
            e.front = d > 0;
            e.u     = e.front ? pixel_quotient(matrix_row(0, w[0], w[1], w[2]), d) : '0;
            e.v     = e.front ? pixel_quotient(matrix_row(1, w[0], w[1], w[2]), d) : '0;
            e.last  = k == 7;
            expected_corners = {expected_corners, e};
         end
         return 8;
      endfunction

      function void check(corner_type got);
         corner_type e;
         corners_checked++;
         if (expected_corners.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected corner idx=%0d u=%h v=%h front=%b last=%b",
                        got.idx, got.u, got.v, got.front, got.last);
            return;
         end
         e = expected_corners.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: corner mismatch exp idx=%0d u=%h v=%h front=%b last=%b,",
                        e.idx, e.u, e.v, e.front, e.last);
               $display("       got idx=%0d u=%h v=%h front=%b last=%b",
                        got.idx, got.u, got.v, got.front, got.last);
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [PAIR_W-1:0]     csr_pwdata = '0;
   logic [PAIR_W-1:0]     csr_prdata;
   logic                  csr_pready;

   corner_scoreboard sb = new();
   bit  no_idling = 1'b0;
   int  stall_left = 0;
   int  idle_cycles = 0;
   int  boxes_sent = 0;
   int  boxes_projected = 0;

   oriented_box_corner_projector u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // centre xyz, quaternion wxyz, sizes xyz
      .req_tuser   (req_tuser),   // is_box
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // corner index, u, v, in-front flag
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Response side: check each accepted corner and stall in random bursts.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         sb.check('{idx: rsp_tdata[2:0], u: rsp_tdata[34:3], v: rsp_tdata[66:35],
                    front: rsp_tdata[67], last: rsp_tlast});
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (no_idling) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on cycles in which nothing is accepted anywhere.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("ERROR: timeout with %0d corners outstanding", sb.expected_corners.size());
         $display("oriented_box_corner_projector_tb NOT OK");
         $finish;
      end
   end

   task automatic write_pair(int idx, logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(8 * idx);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.set_pair(idx, value);
   endtask

   task automatic write_matrix(logic [63:0] p0, p1, p2, p3, p4, p5);
      write_pair(0, p0); write_pair(1, p1); write_pair(2, p2);
      write_pair(3, p3); write_pair(4, p4); write_pair(5, p5);
   endtask

   // Sends one box, with an occasional burst of idle cycles before it.
   task automatic send_box(test_box_type b);
      int gap;
      if (!no_idling && $urandom_range(0, 11) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, b.sz, b.sy, b.sx, b.qz, b.qy, b.qx, b.qw, b.cz, b.cy, b.cx};
      req_tuser  <= b.is_box;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      boxes_sent++;
      if (sb.note_box(b) != 0) boxes_projected++;
   endtask

   // Lowers the request valid and waits until every corner has arrived.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_corners.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic test_box_type mk_box(logic [31:0] cx, cy, cz,
                                           logic [15:0] qw, qx, qy, qz,
                                           logic [30:0] sx, sy, sz, logic is_box);
      return '{cx: cx, cy: cy, cz: cz, qw: qw, qx: qx, qy: qy, qz: qz,
               sx: sx, sy: sy, sz: sz, is_box: is_box};
   endfunction

   // Mostly plausible boxes in front of the camera, plus raw bits and rejects.
   function automatic test_box_type rand_box();
      int           pick;
      test_box_type b;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         b = mk_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom_range(0, 1));
      end else begin
         b = mk_box($urandom_range(0, 40 << 16) - (20 << 16),
                    $urandom_range(0, 40 << 16) - (20 << 16),
                    $urandom_range(1 << 16, 60 << 16),
                    $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                    $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                    $urandom_range(0, 6 << 16), $urandom_range(0, 6 << 16),
                    $urandom_range(0, 6 << 16), 1'b1);
         if (pick < 22) b.is_box = 1'b0;
         else if (pick < 28) b.cz = -$signed(32'($urandom_range(0, 10 << 16)));
      end
      return b;
   endfunction

   // Sends a fixed number of random boxes, whatever share of them is projected.
   task automatic random_boxes(int count);
      repeat (count) send_box(rand_box());
   endtask

   localparam logic [31:0] ONE_M = 32'h0001_0000;
   localparam logic [15:0] Q_ONE = 16'h4000;

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With the matrix still cleared every depth is zero, so nothing comes out.
      send_box(mk_box(0, 0, 10 * ONE_M, Q_ONE, 0, 0, 0, 2 * ONE_M, ONE_M, ONE_M, 1'b1));
      send_box(rand_box());
      drain();

      // Pinhole camera, focal length 500, principal point (320, 240).
      write_matrix({32'h0, 32'h01F4_0000}, {32'h0, 32'h0140_0000},
                   {32'h01F4_0000, 32'h0}, {32'h0, 32'h00F0_0000},
                   {32'h0, 32'h0}, {32'h0, 32'h0001_0000});
      write_pair(6, {64{1'b1}});

      // Directed boxes: rejects, rotations, odd quaternions and field extremes.
      send_box(mk_box(0, 0, 10 * ONE_M, Q_ONE, 0, 0, 0, 2 * ONE_M, ONE_M, 3 * ONE_M / 2, 1'b1));
      send_box(mk_box(0, 0, 10 * ONE_M, Q_ONE, 0, 0, 0, 2 * ONE_M, ONE_M, ONE_M, 1'b0));
      send_box(mk_box(ONE_M, ONE_M, 0, Q_ONE, 0, 0, 0, ONE_M, ONE_M, ONE_M, 1'b1));
      send_box(mk_box(0, 0, -5 * ONE_M, Q_ONE, 0, 0, 0, ONE_M, ONE_M, ONE_M, 1'b1));
      send_box(mk_box(ONE_M, -ONE_M, 8 * ONE_M, 16'd11585, 0, 0, 16'd11585,
                      4 * ONE_M, 2 * ONE_M, ONE_M, 1'b1));
      send_box(mk_box(0, 0, 5 * ONE_M, Q_ONE, 0, 0, 0, 0, 0, 0, 1'b1));
      send_box(mk_box(0, 0, 5 * ONE_M, 0, 0, 0, 0, ONE_M, ONE_M, ONE_M, 1'b1));
      send_box(mk_box(0, 0, 5 * ONE_M, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                      ONE_M, ONE_M, ONE_M, 1'b1));
      send_box(mk_box(0, 0, 5 * ONE_M, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                      ONE_M, ONE_M, ONE_M, 1'b1));
      send_box(mk_box(0, 0, 10 * ONE_M, Q_ONE, 0, 0, 0,
                      31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1));
      send_box(mk_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, Q_ONE, 0, 0, 0,
                      4 * ONE_M, 4 * ONE_M, 4 * ONE_M, 1'b1));
      send_box(mk_box(32'h8000_0000, 32'h8000_0000, ONE_M, Q_ONE, 0, 0, 0,
                      4 * ONE_M, 4 * ONE_M, 4 * ONE_M, 1'b1));
      send_box(mk_box(ONE_M, ONE_M, 1, Q_ONE, 0, 0, 0, ONE_M, ONE_M, ONE_M, 1'b1));
      send_box(mk_box(0, 0, 12 * ONE_M, 0, Q_ONE, 0, 0, 3 * ONE_M, ONE_M, 2 * ONE_M, 1'b1));
      send_box(mk_box(-3 * ONE_M, 2 * ONE_M, 20 * ONE_M, 16'd9000, -16'sd7000, 16'd5000,
                      -16'sd9000, 5 * ONE_M, 3 * ONE_M, 2 * ONE_M, 1'b1));
      random_boxes(60);

      // Hold the sender until the pipeline has emptied completely.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_corners.size() != 0) @(posedge clock);
      random_boxes(90);
      drain();

      // Extreme coefficients in every row.
      write_matrix({32'h8000_0000, 32'h7FFF_FFFF}, {32'h8000_0000, 32'h7FFF_FFFF},
                   {32'h7FFF_FFFF, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h8000_0000},
                   {32'h0, 32'h0}, {32'h8000_0000, 32'h7FFF_FFFF});
      random_boxes(60);
      drain();

      // Fully random matrix.
      write_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      random_boxes(60);
      drain();

      // Tilted camera with a sloped depth row; no idling on either side.
      write_matrix({32'h0010_0000, 32'h0200_0000}, {32'hFF00_0000, 32'h0140_0000},
                   {32'hFFE0_0000, 32'h0000_8000}, {32'h0500_0000, 32'h00F0_0000},
                   {32'hFFFF_F000, 32'h0000_1000}, {32'h0000_4000, 32'h0001_0000});
      no_idling = 1'b1;
      random_boxes(130);
      drain();

      $display("Sent %0d boxes, %0d of them projected, and checked %0d corners",
               boxes_sent, boxes_projected, sb.corners_checked);
      $display("over five camera matrices, including cleared and extreme ones.");
      if (sb.mismatches == 0 && sb.expected_corners.size() == 0) begin
         $display("oriented_box_corner_projector_tb OK");
      end else begin
         $display("Mismatches: %0d", sb.mismatches);
         $display("oriented_box_corner_projector_tb NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
src/ocp_pkg.sv
src/ocp_front.sv
src/ocp_corner.sv
src/ocp_div.sv
src/oriented_box_corner_projector.sv
sim/oriented_box_corner_projector_tb.sv
